>>> sv/dwos_pkg.sv
// Shared types and constants for the daily window output scheduler.
// Holds the request and result payload structs, request kinds and register indexes.
// No dependencies.
package dwos_pkg;

    localparam int NUM_CH      = 5;
    localparam int DAY_MINUTES = 1440;

    // Request kinds.
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_ARM   = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_LIGHT_WINDOW  = 3'd0;
    localparam logic [2:0] REG_FAN_WINDOW    = 3'd4;
    localparam logic [2:0] REG_ZONE_OFFSET   = 3'd5;
    localparam logic [2:0] REG_DEFAULT_HOLD  = 3'd6;

    // Reset values of the registers.
    localparam logic [22:0] WIN_RESET [NUM_CH] = '{
        23'd738480, 23'd860595, 23'd860595, 23'd983535, 23'd1107000
    };
    localparam logic [31:0] DEFAULT_HOLD_RESET = 32'd100000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [47:0] now_ms;
        logic [39:0] wall_seconds;
        logic        time_valid;
        logic [2:0]  target;
        logic [31:0] hold_req_ms;
        logic [4:0]  current_states;
    } item_t;

    typedef struct packed {
        logic [4:0]  set_mask;
        logic [4:0]  drive_states;
        logic        pulse_zone;
        logic        applied;
        logic [10:0] minute_now;
    } result_t;

endpackage

>>> sv/daily_window_output_scheduler_unit.sv
// Top level of the daily window output scheduler.
// Pipeline that derives the local minute of the day, evaluates five channel windows
// and tracks manual overrides. Depends on dwos_pkg.
//
// Usage: requests enter on item/item_valid/item_stall and each one yields exactly one
// result on result/result_valid/result_stall, in request order. Kind tick evaluates
// the windows when time is valid, kind arm starts an override on one channel and
// kind clear drops it and evaluates if time is valid. Configuration is written through
// cfg_write/cfg_index/cfg_data while no request is in flight.
// An accepted request moves through stages 1, 2 and 3 into the output register; one
// request is accepted every cycle while the pipeline is not backed up. The minute
// of the day comes out of three stages (seconds folded modulo one day, folded again,
// scaled by a reciprocal of 15); override state is read and written only in the final
// stage, so a request always sees the overrides left by the one before it.
// Reset clears every override, restores the register defaults and empties the
// pipeline. When the receiver stalls, the result waits in the output register and
// earlier stages keep filling; the request side stalls only once all stages hold work.
module daily_window_output_scheduler_unit
    import dwos_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  item_t       item,
    output logic        result_valid,
    input  logic        result_stall,
    output result_t     result,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    // Fields that ride along the pipeline unchanged.
    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  target;
        logic        time_valid;
        logic [4:0]  current_states;
        logic [47:0] now_ms;
        logic [48:0] expiry;
    } ctx_t;

    localparam logic [10:0] SEC_FOLD1  = 11'd23;     // 2^11 mod 675
    localparam logic [9:0]  SEC_FOLD2  = 10'd529;    // 2^22 mod 675
    localparam logic [11:0] BLOCK      = 12'd675;    // 86400 / 128
    localparam logic [15:0] RECIP_15   = 16'd34953;  // ceil(2^19 / 15)

    function automatic logic window_on(input logic [22:0] w, input logic [10:0] m);
        logic [10:0] st;
        logic [10:0] en;
        logic        on;
        st = w[21:11];
        en = w[10:0];
        if (!w[22])
        begin
            on = 1'b0;
        end
        else if (st == en)
        begin
            on = 1'b1;
        end
        else if (st < en)
        begin
            on = (m >= st) && (m < en);
        end
        else
        begin
            on = (m >= st) || (m < en);
        end
        return on;
    endfunction

    // Configuration registers.
    logic [22:0]        win_reg [NUM_CH];
    logic signed [10:0] zone_offset_reg;
    logic [31:0]        default_hold_reg;

    // Override state.
    logic [NUM_CH-1:0]  ovr_on_reg;
    logic [NUM_CH-1:0]  ovr_on_next;
    logic [48:0]        ovr_exp_reg  [NUM_CH];
    logic [48:0]        ovr_exp_next [NUM_CH];

    // Pipeline registers.
    logic        s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    ctx_t        s1_ctx_reg, s2_ctx_reg, s3_ctx_reg;
    ctx_t        s1_ctx_next;
    logic [20:0] s1_fold_reg, s1_fold_next;
    logic [4:0]  s1_lo_reg;
    logic [14:0] s2_quarter_reg, s2_quarter_next;
    logic [10:0] s3_utc_reg, s3_utc_next;
    result_t     out_reg, out_next;

    logic        out_ready, s3_ready, s2_ready, s1_ready;
    logic        out_fire;

    assign out_ready  = !out_valid_reg || !result_stall;
    assign s3_ready   = !s3_valid_reg || out_ready;
    assign s2_ready   = !s2_valid_reg || s3_ready;
    assign s1_ready   = !s1_valid_reg || s2_ready;
    assign item_stall = !s1_ready;
    assign out_fire   = s3_valid_reg && out_ready;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Stage 1: hold time, expiry sum and the first fold of seconds / 128 modulo 675.
    logic [31:0] hold_ms;
    always_comb
    begin
        hold_ms = (item.hold_req_ms != 32'd0) ? item.hold_req_ms : default_hold_reg;
        s1_ctx_next.kind           = item.kind;
        s1_ctx_next.target         = item.target;
        s1_ctx_next.time_valid     = item.time_valid;
        s1_ctx_next.current_states = item.current_states;
        s1_ctx_next.now_ms         = item.now_ms;
        s1_ctx_next.expiry         = {1'b0, item.now_ms} + {17'd0, hold_ms};
        s1_fold_next = 21'(item.wall_seconds[39:29] * SEC_FOLD2)
                     + 21'(item.wall_seconds[28:18] * SEC_FOLD1)
                     + {10'd0, item.wall_seconds[17:7]};
    end

    // Stage 2: finish the modulo 675 reduction, giving the second of the day / 4.
    logic [14:0] fold_a;
    logic [11:0] fold_b;
    logic [9:0]  day_block;
    always_comb
    begin
        fold_a = 15'(s1_fold_reg[20:11] * 5'd23) + {4'd0, s1_fold_reg[10:0]};
        fold_b = 12'(fold_a[14:11] * 5'd23) + {1'b0, fold_a[10:0]};
        if (fold_b >= 12'(3 * 675))
        begin
            day_block = 10'(fold_b - 12'(3 * 675));
        end
        else if (fold_b >= 12'(2 * 675))
        begin
            day_block = 10'(fold_b - 12'(2 * 675));
        end
        else if (fold_b >= BLOCK)
        begin
            day_block = 10'(fold_b - BLOCK);
        end
        else
        begin
            day_block = fold_b[9:0];
        end
        s2_quarter_next = {day_block, s1_lo_reg};
    end

    // Stage 3: UTC minute of the day = (seconds / 4) / 15 by reciprocal.
    logic [30:0] recip_prod;
    always_comb
    begin
        recip_prod  = 31'(s2_quarter_reg * RECIP_15);
        s3_utc_next = recip_prod[29:19];
    end

    // Final stage: local minute, windows and override bookkeeping.
    logic signed [12:0] local_raw;
    logic [10:0]        minute;
    logic               tgt_ok;
    logic               do_apply;
    logic [NUM_CH-1:0]  want;
    logic [NUM_CH-1:0]  mask;
    always_comb
    begin
        local_raw = $signed({2'b00, s3_utc_reg}) + 13'(zone_offset_reg);
        if (local_raw < 0)
        begin
            minute = 11'(local_raw + 13'(DAY_MINUTES));
        end
        else if (local_raw >= 13'(DAY_MINUTES))
        begin
            minute = 11'(local_raw - 13'(DAY_MINUTES));
        end
        else
        begin
            minute = local_raw[10:0];
        end

        ovr_on_next = ovr_on_reg;
        for (int i = 0; i < NUM_CH; i++)
        begin
            ovr_exp_next[i] = ovr_exp_reg[i];
        end
        tgt_ok   = s3_ctx_reg.target <= 3'(NUM_CH - 1);
        do_apply = 1'b0;
        case (s3_ctx_reg.kind)
            KIND_TICK:
            begin
                do_apply = s3_ctx_reg.time_valid;
            end
            KIND_ARM:
            begin
                if (tgt_ok)
                begin
                    ovr_on_next[s3_ctx_reg.target]  = 1'b1;
                    ovr_exp_next[s3_ctx_reg.target] = s3_ctx_reg.expiry;
                end
            end
            KIND_CLEAR:
            begin
                if (tgt_ok)
                begin
                    ovr_on_next[s3_ctx_reg.target]  = 1'b0;
                    ovr_exp_next[s3_ctx_reg.target] = '0;
                    do_apply = s3_ctx_reg.time_valid;
                end
            end
            default:
            begin
                do_apply = 1'b0;
            end
        endcase

        want = '0;
        mask = '0;
        out_next = '0;
        if (do_apply)
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                want[i] = window_on(win_reg[i], minute);
                // An expired override is dropped and the channel follows its window.
                if (ovr_on_next[i] && ({1'b0, s3_ctx_reg.now_ms} >= ovr_exp_reg[i]))
                begin
                    ovr_on_next[i] = 1'b0;
                end
                if (!ovr_on_next[i] && (s3_ctx_reg.current_states[i] != want[i]))
                begin
                    mask[i] = 1'b1;
                end
            end
            out_next.set_mask     = mask;
            out_next.drive_states = want;
            out_next.pulse_zone   = mask[2];
            out_next.applied      = 1'b1;
            out_next.minute_now   = minute;
        end
    end

    // Control state of the pipeline and the overrides.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ovr_on_reg    <= '0;
            for (int i = 0; i < NUM_CH; i++)
            begin
                ovr_exp_reg[i] <= '0;
            end
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= item_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_ready)
            begin
                out_valid_reg <= s3_valid_reg;
            end
            if (out_fire)
            begin
                ovr_on_reg <= ovr_on_next;
                for (int i = 0; i < NUM_CH; i++)
                begin
                    ovr_exp_reg[i] <= ovr_exp_next[i];
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s1_ready && item_valid)
        begin
            s1_ctx_reg  <= s1_ctx_next;
            s1_fold_reg <= s1_fold_next;
            s1_lo_reg   <= item.wall_seconds[6:2];
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_ctx_reg     <= s1_ctx_reg;
            s2_quarter_reg <= s2_quarter_next;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_ctx_reg <= s2_ctx_reg;
            s3_utc_reg <= s3_utc_next;
        end
        if (out_fire)
        begin
            out_reg <= out_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                win_reg[i] <= WIN_RESET[i];
            end
            zone_offset_reg  <= '0;
            default_hold_reg <= DEFAULT_HOLD_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index >= REG_LIGHT_WINDOW && cfg_index <= REG_FAN_WINDOW)
            begin
                win_reg[cfg_index] <= cfg_data[22:0];
            end
            else if (cfg_index == REG_ZONE_OFFSET)
            begin
                zone_offset_reg <= $signed(cfg_data[10:0]);
            end
            else if (cfg_index == REG_DEFAULT_HOLD)
            begin
                default_hold_reg <= cfg_data;
            end
        end
    end

    // A result that was not evaluated carries no channel writes and no minute.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.applied |->
            result.set_mask == 5'd0 && result.drive_states == 5'd0
            && result.minute_now == 11'd0)
        else $error("unapplied result carries data");

    // The zone pulse request follows the write of channel 2.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.pulse_zone == result.set_mask[2])
        else $error("pulse_zone differs from set_mask bit 2");

    // The local minute is always within one day.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.applied |-> result.minute_now < 11'(DAY_MINUTES))
        else $error("minute_now out of range");

    // With an empty pipeline, a request is never stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg && !s2_valid_reg && !s3_valid_reg && !out_valid_reg |-> !item_stall)
        else $error("request stalled while the pipeline is empty");

    // An override on channel 0 is dropped as soon as it is cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && s3_ctx_reg.kind == KIND_CLEAR && s3_ctx_reg.target == 3'd0
            |=> !ovr_on_reg[0])
        else $error("override on channel 0 survived a clear");

endmodule

>>> tb/testbench.sv
// Self-checking testbench for daily_window_output_scheduler_unit: random and directed
// requests are predicted in step with acceptance, and every result is compared.
// Depends on dwos_pkg and the daily_window_output_scheduler_unit RTL.
module testbench
    import dwos_pkg::*;
();

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int RUN_LIMIT = 500000;
    localparam int HOLD_OFF_CYCLES = 150;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    item_t       item = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    result_t     result;
    logic        cfg_write = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    daily_window_output_scheduler_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Shadow copy of the block's registers and override state.
    logic [22:0]        win_cfg [NUM_CH];
    logic signed [10:0] zone_ofs;
    logic [31:0]        hold_default;
    logic               ovr_on [NUM_CH];
    logic [48:0]        ovr_expiry [NUM_CH];

    item_t   requests_queued [$];
    result_t outcomes_due [$];
    result_t oldest_due;

    logic [47:0] mono_ms = '0;
    logic [39:0] utc_s = '0;
    logic        src_idle = 1'b1;
    logic        sink_idle = 1'b1;
    int          src_gap = 0;
    int          sink_gap = 0;
    int          sink_pick;
    logic        sink_block;
    int          hold_off_req = 0;
    int          hold_off_seen = 0;
    int          hold_off_left = 0;
    int          cycles;
    int          mismatches = 0;
    int          accepted = 0;
    int          settings = 0;
    int          applied_count = 0;
    int          armed_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int idle_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic window_on(logic [22:0] w, int unsigned m);
        int unsigned st;
        int unsigned en;
        st = w[21:11];
        en = w[10:0];
        if (!w[22])
            return 1'b0;
        if (st == en)
            return 1'b1;
        if (st < en)
            return (m >= st) && (m < en);
        return (m >= st) || (m < en);
    endfunction

    function automatic int unsigned local_minute(logic [39:0] wall);
        longint unsigned secs;
        longint mins;
        longint r;
        secs = wall;
        mins = longint'(secs / 60) + longint'(zone_ofs);
        r = mins % DAY_MINUTES;
        if (r < 0)
            r += DAY_MINUTES;
        return int'(r);
    endfunction

    // Evaluates all windows at the request's minute and retires expired overrides.
    function automatic result_t evaluate_windows(item_t rq);
        result_t res;
        int unsigned m;
        logic want;
        logic hold;
        res = '0;
        m = local_minute(rq.wall_seconds);
        for (int i = 0; i < NUM_CH; i++)
        begin
            want = window_on(win_cfg[i], m);
            hold = 1'b0;
            res.drive_states[i] = want;
            if (ovr_on[i])
            begin
                if ({1'b0, rq.now_ms} >= ovr_expiry[i])
                    ovr_on[i] = 1'b0;
                else
                    hold = 1'b1;
            end
            if (!hold && (rq.current_states[i] != want))
                res.set_mask[i] = 1'b1;
        end
        res.pulse_zone = res.set_mask[2];
        res.applied = 1'b1;
        res.minute_now = 11'(m);
        applied_count++;
        return res;
    endfunction

    function automatic result_t schedule_outcome(item_t rq);
        result_t res;
        logic [31:0] span;
        res = '0;
        case (rq.kind)
            KIND_TICK:
                if (rq.time_valid)
                    res = evaluate_windows(rq);
            KIND_ARM:
                if (rq.target < NUM_CH)
                begin
                    span = (rq.hold_req_ms != 0) ? rq.hold_req_ms : hold_default;
                    ovr_on[rq.target] = 1'b1;
                    ovr_expiry[rq.target] = {1'b0, rq.now_ms} + 49'(span);
                    armed_count++;
                end
            KIND_CLEAR:
                if (rq.target < NUM_CH)
                begin
                    ovr_on[rq.target] = 1'b0;
                    ovr_expiry[rq.target] = '0;
                    if (rq.time_valid)
                        res = evaluate_windows(rq);
                end
            default:
                ;
        endcase
        return res;
    endfunction

    function automatic void compare_field(string name, longint unsigned want,
                                          longint unsigned got);
        if (want != got)
        begin
            $error("%s expected %0h got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic item_t make_request(logic [1:0] kind, logic [47:0] now,
                                           logic [39:0] wall, logic valid,
                                           logic [2:0] target, logic [31:0] dur,
                                           logic [4:0] cur);
        item_t rq;
        rq.kind = kind;
        rq.now_ms = now;
        rq.wall_seconds = wall;
        rq.time_valid = valid;
        rq.target = target;
        rq.hold_req_ms = dur;
        rq.current_states = cur;
        return rq;
    endfunction

    // Mostly a monotonic clock moving forward so overrides expire naturally, with
    // occasional jumps anywhere in the field range.
    function automatic item_t random_request();
        item_t rq;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 3)
            mono_ms = 48'({$urandom, $urandom});
        else if (r < 5)
            mono_ms = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 100000));
        else
            mono_ms = mono_ms + 48'($urandom_range(0, 40000));
        r = $urandom_range(0, 99);
        if (r < 3)
            utc_s = 40'({$urandom, $urandom});
        else
            utc_s = utc_s + 40'($urandom_range(0, 1800));
        rq.now_ms = mono_ms;
        rq.wall_seconds = utc_s;
        r = $urandom_range(0, 99);
        if (r < 55)
            rq.kind = KIND_TICK;
        else if (r < 75)
            rq.kind = KIND_ARM;
        else if (r < 93)
            rq.kind = KIND_CLEAR;
        else
            rq.kind = KIND_UNUSED;
        rq.target = ($urandom_range(0, 99) < 88) ? 3'($urandom_range(0, 4))
                                                 : 3'($urandom_range(5, 7));
        rq.time_valid = ($urandom_range(0, 99) < 92);
        r = $urandom_range(0, 99);
        if (r < 45)
            rq.hold_req_ms = '0;
        else if (r < 80)
            rq.hold_req_ms = $urandom_range(1, 60000);
        else if (r < 88)
            rq.hold_req_ms = 32'hFFFF_FFFF;
        else
            rq.hold_req_ms = $urandom;
        rq.current_states = 5'($urandom_range(0, 31));
        return rq;
    endfunction

    function automatic logic [22:0] random_window();
        logic [10:0] st;
        logic [10:0] en;
        st = 11'($urandom_range(0, DAY_MINUTES - 1));
        en = 11'($urandom_range(0, DAY_MINUTES - 1));
        case ($urandom_range(0, 5))
            0: return {1'b0, 22'($urandom)};
            1: return {1'b1, st, st};
            2: return {1'b1, (st < en) ? st : en, (st < en) ? en : st};
            3: return {1'b1, (st > en) ? st : en, (st > en) ? en : st};
            4: return {1'b1, 11'($urandom_range(0, 2047)), 11'($urandom_range(1440, 2047))};
            default: return {1'b1, st, en};
        endcase
    endfunction

    // One register write per clock; the caller lowers cfg_write after the last one.
    task automatic set_register(logic [2:0] idx, logic [31:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        if (idx <= REG_FAN_WINDOW)
            win_cfg[idx] = data[22:0];
        else if (idx == REG_ZONE_OFFSET)
            zone_ofs = data[10:0];
        else if (idx == REG_DEFAULT_HOLD)
            hold_default = data;
    endtask

    task automatic configure(logic [10:0] ofs, logic [31:0] hold_ms);
        logic [31:0] d;
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            d = $urandom;
            d[22:0] = random_window();
            set_register(REG_LIGHT_WINDOW + 3'(ch), d);
        end
        d = $urandom;
        d[10:0] = ofs;
        set_register(REG_ZONE_OFFSET, d);
        set_register(REG_DEFAULT_HOLD, hold_ms);
        @(posedge clk);
        cfg_write <= 1'b0;
        settings++;
    endtask

    task automatic settle();
        while (requests_queued.size() != 0 || item_valid || outcomes_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_batch(int n);
        for (int i = 0; i < n; i++)
            requests_queued.push_back(random_request());
        settle();
    endtask

    // Sender: offers the next queued request once the current one is taken.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && !item_stall)
            begin
                outcomes_due.push_back(schedule_outcome(item));
                accepted++;
            end
            if (!item_valid || !item_stall)
            begin
                if (src_gap > 0)
                begin
                    src_gap <= src_gap - 1;
                    item_valid <= 1'b0;
                end
                else if (requests_queued.size() != 0)
                begin
                    item <= requests_queued.pop_front();
                    item_valid <= 1'b1;
                    src_gap <= src_idle ? idle_length() : 0;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // Receiver: checks each result against the oldest prediction and stalls at random.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (outcomes_due.size() == 0)
                begin
                    $error("result arrived with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    oldest_due = outcomes_due.pop_front();
                    compare_field("set_mask", oldest_due.set_mask, result.set_mask);
                    compare_field("drive_states", oldest_due.drive_states, result.drive_states);
                    compare_field("pulse_zone", oldest_due.pulse_zone, result.pulse_zone);
                    compare_field("applied", oldest_due.applied, result.applied);
                    compare_field("minute_now", oldest_due.minute_now, result.minute_now);
                end
            end
            if (sink_gap > 0)
            begin
                sink_gap <= sink_gap - 1;
                sink_block = 1'b1;
            end
            else
            begin
                sink_pick = sink_idle ? idle_length() : 0;
                sink_gap <= (sink_pick > 0) ? sink_pick - 1 : 0;
                sink_block = (sink_pick > 0);
            end
            result_stall <= sink_block || (hold_off_left != 0);
        end
    end

    // Long receiver hold-off so the pipeline fills and backs up into the request side.
    always @(posedge clk)
    begin
        if (hold_off_left != 0)
            hold_off_left <= hold_off_left - 1;
        else if (hold_off_req != hold_off_seen)
        begin
            hold_off_left <= HOLD_OFF_CYCLES;
            hold_off_seen <= hold_off_req;
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < RUN_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("daily_window_output_scheduler_unit: mismatch");
        $finish;
    end

    initial
    begin
        win_cfg = WIN_RESET;
        zone_ofs = '0;
        hold_default = DEFAULT_HOLD_RESET;
        for (int i = 0; i < NUM_CH; i++)
        begin
            ovr_on[i] = 1'b0;
            ovr_expiry[i] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed requests against the reset register values.
        requests_queued.push_back(make_request(KIND_TICK, 48'd0, 40'd0, 1'b1, 3'd0, 32'd0, 5'd0));
        requests_queued.push_back(make_request(KIND_TICK, 48'd0, 40'hFF_FFFF_FFFF, 1'b1,
                                               3'd0, 32'd0, 5'd31));
        requests_queued.push_back(make_request(KIND_TICK, 48'd5, 40'd600, 1'b0, 3'd0, 32'd0, 5'd31));
        requests_queued.push_back(make_request(KIND_UNUSED, 48'd5, 40'd600, 1'b1,
                                               3'd0, 32'd9, 5'd31));
        requests_queued.push_back(make_request(KIND_ARM, 48'd1000, 40'd0, 1'b1, 3'd0, 32'd0, 5'd0));
        requests_queued.push_back(make_request(KIND_TICK, 48'd100999, 40'd60, 1'b1,
                                               3'd0, 32'd0, 5'd31));
        requests_queued.push_back(make_request(KIND_TICK, 48'd101000, 40'd60, 1'b1,
                                               3'd0, 32'd0, 5'd31));
        requests_queued.push_back(make_request(KIND_ARM, 48'hFFFF_FFFF_FFFF, 40'd0, 1'b1,
                                               3'd4, 32'hFFFF_FFFF, 5'd0));
        requests_queued.push_back(make_request(KIND_TICK, 48'hFFFF_FFFF_FFFF, 40'd120, 1'b1,
                                               3'd0, 32'd0, 5'd31));
        requests_queued.push_back(make_request(KIND_CLEAR, 48'd0, 40'd86399, 1'b1,
                                               3'd4, 32'd0, 5'd31));
        requests_queued.push_back(make_request(KIND_ARM, 48'd0, 40'd0, 1'b1, 3'd5, 32'd7, 5'd0));
        requests_queued.push_back(make_request(KIND_ARM, 48'd0, 40'd0, 1'b1, 3'd7, 32'd7, 5'd0));
        requests_queued.push_back(make_request(KIND_CLEAR, 48'd0, 40'd0, 1'b1, 3'd6, 32'd0, 5'd31));
        requests_queued.push_back(make_request(KIND_ARM, 48'd10, 40'd0, 1'b1, 3'd2, 32'd5, 5'd0));
        requests_queued.push_back(make_request(KIND_CLEAR, 48'd10, 40'd0, 1'b0, 3'd2, 32'd0, 5'd31));
        requests_queued.push_back(make_request(KIND_TICK, 48'd10, 40'd0, 1'b1, 3'd0, 32'd0, 5'd31));
        requests_queued.push_back(make_request(KIND_ARM, 48'd10, 40'd0, 1'b1, 3'd1, 32'd5, 5'd0));
        requests_queued.push_back(make_request(KIND_ARM, 48'd10, 40'd0, 1'b1, 3'd3, 32'd0, 5'd0));
        requests_queued.push_back(make_request(KIND_TICK, 48'd14, 40'd0, 1'b1, 3'd0, 32'd0, 5'd31));
        requests_queued.push_back(make_request(KIND_TICK, 48'd15, 40'd0, 1'b1, 3'd0, 32'd0, 5'd31));
        requests_queued.push_back(make_request(KIND_TICK, 48'hFFFF_FFFF_FFFF, 40'h01_2345_6789,
                                               1'b1, 3'd0, 32'd0, 5'd10));
        settle();

        // Register settings, the zone offset and hold time extremes among them.
        configure(11'(-720), 32'd0);
        run_batch(200);

        // A stretch with no idling on either side.
        src_idle = 1'b0;
        sink_idle = 1'b0;
        configure(11'd840, 32'hFFFF_FFFF);
        run_batch(200);

        // The receiver holds off while the sender keeps offering requests.
        sink_idle = 1'b1;
        configure(11'h400, 32'd1);
        hold_off_req <= hold_off_req + 1;
        run_batch(200);
        src_idle = 1'b1;

        configure(11'h3FF, 32'($urandom_range(1, 5000)));
        run_batch(200);

        for (int p = 0; p < 4; p++)
        begin
            configure(11'($signed($urandom_range(0, 1560)) - 720),
                      32'($urandom_range(1, 200000)));
            run_batch(200);
        end

        repeat (8) @(posedge clk);
        $display("%0d requests checked over %0d register settings", accepted, settings);
        $display("%0d schedule evaluations, %0d overrides armed", applied_count, armed_count);
        if (mismatches == 0)
            $display("daily_window_output_scheduler_unit: match");
        else
            $display("daily_window_output_scheduler_unit: mismatch");
        $finish;
    end

endmodule
